// ===== hdl/mbps_pkg.sv =====
// Shared types, codes and helpers of the masked byte pattern scanner.
package mbps_pkg;

  localparam logic [7:0] CH_WILD  = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic FUNC_SIG = 1'b0;
  localparam logic FUNC_IMG = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef struct packed {
    logic       func;
    logic [7:0] value;
    logic       last;
  } item_t;

  typedef struct packed {
    logic scan_clr;
    logic pat_bad;
  } ctl_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
  } res_t;

  // Returns {valid, nibble} for one ASCII hex digit.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]:               r = {1'b1, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/mbps_in_if.sv =====
// Input word channel: function select, character or image byte, last flag.
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] value;
  logic       last;

  modport source (output valid, func, value, last, input ready);
  modport sink (input valid, func, value, last, output ready);
endinterface

// ===== hdl/mbps_out_if.sv =====
// Result word channel: search status and match address.
interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;

  modport source (output valid, status, address, input ready);
  modport sink (input valid, status, address, output ready);
endinterface

// ===== hdl/mbps_compiler.sv =====
// Signature compiler: parses characters into an end-aligned masked pattern.
module mbps_compiler #(
  parameter int MAX_PATTERN = 32,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  mbps_pkg::item_t        item_i,
  output logic [7:0]             al_o [MAX_PATTERN],
  output logic [MAX_PATTERN-1:0] wild_o,
  output logic [MAX_PATTERN-1:0] inuse_o,
  output logic [LW-1:0]          len_o,
  output mbps_pkg::ctl_t         ctl_o
);
  import mbps_pkg::*;

  logic [7:0]             al_q [MAX_PATTERN];
  logic [7:0]             al_d [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] wild_q, wild_d, inuse_q, inuse_d;
  logic [LW-1:0]          len_q, len_d;
  logic [3:0]             hi_q, hi_d;
  logic                   phase_q, phase_d, prevw_q, prevw_d;
  logic                   err_q, err_d, closed_q, closed_d;
  logic                   sig_step, al_we;
  logic                   add_en, add_wild;
  logic [7:0]             add_byte;
  logic [4:0]             hex;

  assign sig_step = step_i && (item_i.func == FUNC_SIG);
  assign hex      = hex_decode(item_i.value);

  always_comb begin
    wild_d   = wild_q;
    inuse_d  = inuse_q;
    len_d    = len_q;
    hi_d     = hi_q;
    phase_d  = phase_q;
    prevw_d  = prevw_q;
    err_d    = err_q;
    closed_d = closed_q;
    add_en   = 1'b0;
    add_wild = 1'b0;
    add_byte = 8'd0;
    al_we    = 1'b0;
    if (sig_step) begin
      if (closed_q) begin
        wild_d  = '0;
        inuse_d = '0;
        len_d   = '0;
        hi_d    = 4'd0;
        phase_d = 1'b0;
        prevw_d = 1'b0;
        err_d   = 1'b0;
      end
      if (!err_d) begin
        if (item_i.value == CH_SPACE) begin
          if (phase_d) err_d = 1'b1;
          prevw_d = 1'b0;
        end else if (item_i.value == CH_WILD) begin
          if (phase_d) begin
            err_d = 1'b1;
          end else if (prevw_d) begin
            prevw_d = 1'b0;
          end else begin
            add_en   = 1'b1;
            add_wild = 1'b1;
            prevw_d  = 1'b1;
          end
        end else begin
          prevw_d = 1'b0;
          if (!hex[4]) begin
            err_d = 1'b1;
          end else if (!phase_d) begin
            hi_d    = hex[3:0];
            phase_d = 1'b1;
          end else begin
            phase_d  = 1'b0;
            add_en   = 1'b1;
            add_byte = {hi_d, hex[3:0]};
          end
        end
      end
      if (add_en) begin
        if (len_d == LW'(MAX_PATTERN)) begin
          err_d = 1'b1;
        end else begin
          al_we = 1'b1;
          for (int k = MAX_PATTERN - 1; k > 0; k--) begin
            wild_d[k]  = wild_d[k-1];
            inuse_d[k] = inuse_d[k-1];
          end
          wild_d[0]  = add_wild;
          inuse_d[0] = 1'b1;
          len_d      = len_d + LW'(1);
        end
      end
      if (item_i.last && phase_d) err_d = 1'b1;
      closed_d = item_i.last;
    end
  end

  always_comb begin
    for (int k = 1; k < MAX_PATTERN; k++) begin
      al_d[k] = al_q[k-1];
    end
    al_d[0] = add_byte;
  end

  always_ff @(posedge clk_i) begin
    if (al_we) begin
      al_q <= al_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wild_q   <= '0;
      inuse_q  <= '0;
      len_q    <= '0;
      hi_q     <= 4'd0;
      phase_q  <= 1'b0;
      prevw_q  <= 1'b0;
      err_q    <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      wild_q   <= wild_d;
      inuse_q  <= inuse_d;
      len_q    <= len_d;
      hi_q     <= hi_d;
      phase_q  <= phase_d;
      prevw_q  <= prevw_d;
      err_q    <= err_d;
      closed_q <= closed_d;
    end
  end

  assign al_o           = al_q;
  assign wild_o         = wild_q;
  assign inuse_o        = inuse_q;
  assign len_o          = len_q;
  assign ctl_o.scan_clr = sig_step && closed_q;
  assign ctl_o.pat_bad  = err_q || phase_q || (len_q == '0);

endmodule

// ===== hdl/mbps_scanner.sv =====
// Image scanner: byte window, parallel masked compare, first-match latch, report.
module mbps_scanner #(
  parameter int MAX_PATTERN = 32,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  mbps_pkg::item_t        item_i,
  input  mbps_pkg::ctl_t         ctl_i,
  input  logic [7:0]             al_i [MAX_PATTERN],
  input  logic [MAX_PATTERN-1:0] wild_i,
  input  logic [MAX_PATTERN-1:0] inuse_i,
  input  logic [LW-1:0]          len_i,
  input  logic [31:0]            base_i,
  output mbps_pkg::res_t         res_o
);
  import mbps_pkg::*;

  logic [7:0]  win_q [MAX_PATTERN];
  logic [7:0]  win_d [MAX_PATTERN];
  logic [31:0] seen_q, seen_d, seen_n, len_ext, offset_q, offset_d, offset_n;
  logic        latched_q, latched_d, latched_n;
  logic        img_step, hit, all_eq;

  assign img_step = step_i && (item_i.func == FUNC_IMG);
  assign len_ext  = 32'(len_i);

  always_comb begin
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
    win_d[0] = item_i.value;
  end

  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (inuse_i[k] && !wild_i[k] && (win_d[k] != al_i[k])) all_eq = 1'b0;
    end
  end

  assign seen_n    = (seen_q == '1) ? seen_q : seen_q + 32'd1;
  assign hit       = all_eq && (len_i != '0) && (seen_n >= len_ext);
  assign latched_n = latched_q || hit;
  assign offset_n  = latched_q ? offset_q : seen_n - len_ext;

  always_comb begin
    seen_d    = seen_q;
    latched_d = latched_q;
    offset_d  = offset_q;
    if (img_step) begin
      if (item_i.last) begin
        seen_d    = '0;
        latched_d = 1'b0;
      end else begin
        seen_d    = seen_n;
        latched_d = latched_n;
        offset_d  = offset_n;
      end
    end else if (step_i && ctl_i.scan_clr) begin
      seen_d    = '0;
      latched_d = 1'b0;
    end
  end

  always_comb begin
    if (ctl_i.pat_bad) begin
      res_o.status  = ST_BAD;
      res_o.address = '0;
    end else if (latched_n) begin
      res_o.status  = ST_MATCH;
      res_o.address = base_i + offset_n;
    end else begin
      res_o.status  = ST_NOMATCH;
      res_o.address = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (img_step) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      latched_q <= 1'b0;
      offset_q  <= '0;
    end else begin
      seen_q    <= seen_d;
      latched_q <= latched_d;
      offset_q  <= offset_d;
    end
  end

endmodule

// ===== hdl/masked_byte_pattern_search_core.sv =====
// Top level of the masked byte pattern scanner.
// The last image word is held in the input register, and its result then loads the output register.
// Throughput: one word per cycle, unless a report waits on an unready, full output register;
// pattern update and window compare finish in the single stage between input and output registers.
// Reset (async, active low) empties both registers, the pattern, the scan and the base.
module masked_byte_pattern_search_core #(
  parameter int MAX_PATTERN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  mbps_in_if.sink     in_i,
  mbps_out_if.source  out_o
);
  import mbps_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  item_t                  s1_q;
  logic                   s1_valid_q, s1_valid_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   out_q, res;
  logic [31:0]            base_q;
  logic                   report, advance, in_fire, out_load;
  logic [7:0]             al [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] wild, inuse;
  logic [LW-1:0]          len;
  ctl_t                   ctl;

  assign report   = s1_valid_q && (s1_q.func == FUNC_IMG) && s1_q.last;
  assign advance  = s1_valid_q && (!report || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_load = advance && report;

  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  mbps_compiler #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_compiler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (s1_q),
    .al_o    (al),
    .wild_o  (wild),
    .inuse_o (inuse),
    .len_o   (len),
    .ctl_o   (ctl)
  );

  mbps_scanner #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (s1_q),
    .ctl_i   (ctl),
    .al_i    (al),
    .wild_i  (wild),
    .inuse_i (inuse),
    .len_i   (len),
    .base_i  (base_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= '{func: in_i.func, value: in_i.value, last: in_i.last};
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_q.status;
  assign out_o.address = out_q.address;

  a_no_addr_unless_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_MATCH) |-> out_q.address == '0)
    else $error("address set on a result without a match");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && report && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked report");

  a_report_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && report |=> out_valid_q)
    else $error("report word did not reach the output register");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !report && out_o.ready |=> !out_valid_q)
    else $error("result word appeared without a report");

endmodule
